// ===== rtl/dcb_pkg.sv =====
package dcb_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 24;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int CHUNK_W = 12;
    localparam int AMASK_W = 6;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int DEF_MAX_DESCRIPTORS = 64;
    localparam int DEF_ADDR_WIDTH      = 32;

    localparam logic [CHUNK_W:0] PAGE_SIZE = 13'h1000;

    localparam logic [AMASK_W-1:0] AMASK_4  = 6'd3;
    localparam logic [AMASK_W-1:0] AMASK_16 = 6'd15;
    localparam logic [AMASK_W-1:0] AMASK_32 = 6'd31;
    localparam logic [AMASK_W-1:0] AMASK_64 = 6'd63;

    localparam logic [1:0] BLK_32B = 2'd1;
    localparam logic [1:0] BLK_64B = 2'd2;

    localparam logic [1:0] REG_MAX_CHUNK   = 2'd0;
    localparam logic [1:0] REG_BURST_CHUNK = 2'd1;
    localparam logic [1:0] REG_BURST_EN    = 2'd2;
    localparam logic [1:0] REG_EXT_BLOCK   = 2'd3;

    localparam logic [CHUNK_W-1:0] RST_MAX_CHUNK   = 12'd4095;
    localparam logic [CHUNK_W-1:0] RST_BURST_CHUNK = 12'd4092;

    typedef struct packed {
        logic [CHUNK_W-1:0] max_chunk;
        logic [CHUNK_W-1:0] burst_chunk;
        logic               burst_enable;
        logic [1:0]         ext_block_size;
    } t_cfg;

endpackage

// ===== rtl/dcb_if.sv =====
interface dcb_req_if;
    import dcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] buf_addr;
    logic [LEN_W-1:0]  length;
    logic [CNT_W-1:0]  desc_count;
    logic              tx;
    logic              in_ext_mem;

    modport source (output valid, buf_addr, length, desc_count, tx, in_ext_mem,
                    input ready);
    modport sink   (input valid, buf_addr, length, desc_count, tx, in_ext_mem,
                    output ready);
endinterface

interface dcb_desc_if;
    import dcb_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   desc_index;
    logic               owner;
    logic               eof;
    logic [CHUNK_W-1:0] xfer_len;
    logic [CHUNK_W-1:0] buf_len;
    logic [ADDR_W-1:0]  seg_addr;
    logic               next_valid;
    logic               last;
    logic [LEN_W-1:0]   bound_bytes;

    modport source (output valid, desc_index, owner, eof, xfer_len, buf_len, seg_addr,
                    next_valid, last, bound_bytes,
                    input ready);
    modport sink   (input valid, desc_index, owner, eof, xfer_len, buf_len, seg_addr,
                    next_valid, last, bound_bytes,
                    output ready);
endinterface

// ===== rtl/dcb_cfg_regs.sv =====
module dcb_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcb_pkg::PADDR_W-1:0] paddr,
    input  logic [dcb_pkg::PDATA_W-1:0] pwdata,
    output logic [dcb_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output dcb_pkg::t_cfg                o_cfg
);
    import dcb_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_sel;
    logic       w_wr;

    assign w_sel  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_chunk      <= RST_MAX_CHUNK;
            r_cfg.burst_chunk    <= RST_BURST_CHUNK;
            r_cfg.burst_enable   <= 1'b0;
            r_cfg.ext_block_size <= 2'd0;
        end else if (w_wr) begin
            case (w_sel)
                REG_MAX_CHUNK:   r_cfg.max_chunk      <= pwdata[CHUNK_W-1:0];
                REG_BURST_CHUNK: r_cfg.burst_chunk    <= pwdata[CHUNK_W-1:0];
                REG_BURST_EN:    r_cfg.burst_enable   <= pwdata[0];
                REG_EXT_BLOCK:   r_cfg.ext_block_size <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_sel)
            REG_MAX_CHUNK:   prdata[CHUNK_W-1:0] = r_cfg.max_chunk;
            REG_BURST_CHUNK: prdata[CHUNK_W-1:0] = r_cfg.burst_chunk;
            REG_BURST_EN:    prdata[0]           = r_cfg.burst_enable;
            REG_EXT_BLOCK:   prdata[1:0]         = r_cfg.ext_block_size;
            default:         prdata              = '0;
        endcase
    end

endmodule

// ===== rtl/dma_descriptor_chain_builder_unit.sv =====
// Scatter-gather descriptor chain builder.
// i_req: one buffer request (address, byte length, descriptor budget, direction,
//   external-memory flag), valid/ready; taken only while no request is in work.
// o_desc: one descriptor per chunk in chain order, valid/ready; the final one
//   carries last, a null link and the bytes bound, and eof for transmit.
// APB port: four registers at byte addresses 0, 4, 8, 12 (max chunk, burst
//   chunk, burst enable, external block size); write only while idle.
// Flow: the request is taken while idle, then one shared length/address
//   unit produces one descriptor per cycle into the output register whenever
//   that register is empty or being taken. The first descriptor is loaded
//   once the sequencer has entered its run state. The next request is taken
//   as soon as the last descriptor is loaded, while it still waits in the
//   output register.
// Stall: when o_desc.ready is low, the output register holds and the unit
//   waits; nothing is dropped.
// Reset: synchronous, active low; clears the sequencer and output valid and
//   restores register defaults (4095, 4092, burst off, 16-byte blocks).
module dma_descriptor_chain_builder_unit #(
    parameter int MAX_DESCRIPTORS = dcb_pkg::DEF_MAX_DESCRIPTORS,
    parameter int ADDR_WIDTH      = dcb_pkg::DEF_ADDR_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dcb_req_if.sink                      i_req,
    dcb_desc_if.source                   o_desc,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcb_pkg::PADDR_W-1:0] paddr,
    input  logic [dcb_pkg::PDATA_W-1:0] pwdata,
    output logic [dcb_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import dcb_pkg::*;

    localparam int AW = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DESCRIPTORS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    t_cfg w_cfg;

    logic               r_state;
    logic [LEN_W-1:0]   r_rem;
    logic [LEN_W-1:0]   r_length;
    logic [AW-1:0]      r_addr;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_budget;
    logic [CHUNK_W-1:0] r_limit;
    logic [AMASK_W-1:0] r_amask;
    logic               r_tx;
    logic               r_rounded;

    logic               r_ovalid;
    logic [IDX_W-1:0]   r_oidx;
    logic               r_oeof;
    logic [CHUNK_W-1:0] r_odlen;
    logic [CHUNK_W-1:0] r_oblen;
    logic [ADDR_W-1:0]  r_oseg;
    logic               r_olast;
    logic [LEN_W-1:0]   r_obound;

    logic               w_accept;
    logic               w_step;
    logic [CNT_W-1:0]   w_budget;
    logic [AMASK_W-1:0] w_amask;
    logic [CHUNK_W-1:0] w_limit;
    logic               w_rx_ext;
    logic [CHUNK_W-1:0] w_dlen;
    logic [CHUNK_W:0]   w_bsum;
    logic [CHUNK_W-1:0] w_blen;
    logic [LEN_W-1:0]   n_rem;
    logic               w_fin;
    logic [ADDR_W-1:0]  w_seg;

    dcb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_step      = (r_state == S_RUN) && (!r_ovalid || o_desc.ready);
    assign w_rx_ext    = !i_req.tx && i_req.in_ext_mem;

    always_comb begin
        w_budget = i_req.desc_count;
        if (i_req.desc_count == '0) begin
            w_budget = CNT_W'(1);
        end else if (i_req.desc_count > MAX_CNT) begin
            w_budget = MAX_CNT;
        end
        w_amask = AMASK_4;
        w_limit = w_cfg.max_chunk;
        if (w_rx_ext) begin
            case (w_cfg.ext_block_size)
                BLK_64B: w_amask = AMASK_64;
                BLK_32B: w_amask = AMASK_32;
                default: w_amask = AMASK_16;
            endcase
            w_limit = CHUNK_W'(PAGE_SIZE - (CHUNK_W+1)'(w_amask) - (CHUNK_W+1)'(1));
        end else if (!i_req.tx && w_cfg.burst_enable) begin
            w_limit = {w_cfg.burst_chunk[CHUNK_W-1:2], 2'b00};
        end
    end

    always_comb begin
        w_dlen = (r_rem < LEN_W'(r_limit)) ? r_rem[CHUNK_W-1:0] : r_limit;
        w_bsum = ({1'b0, w_dlen} + (CHUNK_W+1)'(r_amask)) & ~(CHUNK_W+1)'(r_amask);
        w_blen = r_rounded ? w_bsum[CHUNK_W-1:0] : w_dlen;
        n_rem  = r_rem - LEN_W'(w_dlen);
        w_fin  = (n_rem == '0) || ((CNT_W'(r_idx) + CNT_W'(1)) == r_budget);
        w_seg  = '0;
        w_seg[AW-1:0] = r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE:  if (w_accept) r_state <= S_RUN;
                S_RUN:   if (w_step && w_fin) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (w_step) begin
                r_ovalid <= 1'b1;
            end else if (o_desc.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rem     <= i_req.length;
            r_length  <= i_req.length;
            r_addr    <= i_req.buf_addr[AW-1:0];
            r_idx     <= '0;
            r_budget  <= w_budget;
            r_limit   <= w_limit;
            r_amask   <= w_amask;
            r_tx      <= i_req.tx;
            r_rounded <= !i_req.tx && (w_cfg.burst_enable || i_req.in_ext_mem);
        end else if (w_step) begin
            r_rem  <= n_rem;
            r_addr <= r_addr + AW'(w_dlen);
            r_idx  <= r_idx + IDX_W'(1);
        end
        if (w_step) begin
            r_oidx   <= r_idx;
            r_oeof   <= w_fin && r_tx;
            r_odlen  <= r_tx ? w_dlen : '0;
            r_oblen  <= w_blen;
            r_oseg   <= w_seg;
            r_olast  <= w_fin;
            r_obound <= w_fin ? (r_length - n_rem) : '0;
        end
    end

    assign o_desc.valid       = r_ovalid;
    assign o_desc.desc_index  = r_oidx;
    assign o_desc.owner       = 1'b1;
    assign o_desc.eof         = r_oeof;
    assign o_desc.xfer_len    = r_odlen;
    assign o_desc.buf_len     = r_oblen;
    assign o_desc.seg_addr    = r_oseg;
    assign o_desc.next_valid  = !r_olast;
    assign o_desc.last        = r_olast;
    assign o_desc.bound_bytes = r_obound;

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_state == S_RUN))
        else $error("non-final descriptor pending while idle");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_rem <= r_length))
        else $error("remaining bytes exceed request length");

    a_idx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && o_desc.ready && !r_olast)
        |=> (!r_ovalid || (r_oidx == $past(r_oidx) + IDX_W'(1))))
        else $error("descriptor index skipped");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oeof) |-> r_olast)
        else $error("end of frame on a non-final descriptor");

    a_bound_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_obound == '0))
        else $error("bytes bound reported before the final descriptor");

endmodule

// ===== verif/dma_descriptor_chain_builder_unit_tb.sv =====
`timescale 1ns / 100ps

module dma_descriptor_chain_builder_unit_tb;
    import dcb_pkg::*;

    localparam int MAX_DESC     = DEF_MAX_DESCRIPTORS;
    localparam int DRAIN_CYCLES = 2 * (MAX_DESC + 1);
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_OFF_LEN = 400;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ADDR_W-1:0]  buf_addr;
        logic [LEN_W-1:0]   length;
        logic [CNT_W-1:0]   desc_count;
        logic               tx;
        logic               in_ext_mem;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   desc_index;
        logic               owner;
        logic               eof;
        logic [CHUNK_W-1:0] xfer_len;
        logic [CHUNK_W-1:0] buf_len;
        logic [ADDR_W-1:0]  seg_addr;
        logic               next_valid;
        logic               last;
        logic [LEN_W-1:0]   bound_bytes;
    } desc_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dcb_req_if  req_bus ();
    dcb_desc_if desc_bus ();

    dma_descriptor_chain_builder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_desc  (desc_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg  cfg_shadow;
    desc_t expected_descs[$];
    int    error_count   = 0;
    int    idle_cycles   = 0;
    int    burst_left    = 0;
    bit    gaps_enabled  = 1'b1;
    int    hold_off_req  = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Expected descriptors of one request under the current register settings
    task automatic build_chain(input req_t r);
        logic [ADDR_W-1:0] addr;
        int unsigned remaining, budget, amask, limit, dlen, blen, bound, i;
        bit          rounded, fin;
        desc_t       d;
        addr      = r.buf_addr;
        remaining = r.length;
        budget    = r.desc_count;
        if (budget == 0) budget = 1;
        if (budget > MAX_DESC) budget = MAX_DESC;
        amask = AMASK_4;
        limit = cfg_shadow.max_chunk;
        if (!r.tx && r.in_ext_mem) begin
            case (cfg_shadow.ext_block_size)
                BLK_64B: amask = AMASK_64;
                BLK_32B: amask = AMASK_32;
                default: amask = AMASK_16;
            endcase
            limit = PAGE_SIZE - (amask + 1);
        end else if (!r.tx && cfg_shadow.burst_enable) begin
            limit = {cfg_shadow.burst_chunk[CHUNK_W-1:2], 2'b00};
        end
        rounded = !r.tx && (cfg_shadow.burst_enable || r.in_ext_mem);
        fin = 1'b0;
        for (i = 0; i < budget && !fin; i++) begin
            dlen = (remaining < limit) ? remaining : limit;
            blen = rounded ? ((dlen + amask) & ~amask) : dlen;
            remaining = remaining - dlen;
            fin = (remaining == 0) || (i + 1 == budget);
            bound = r.length - remaining;
            d.desc_index  = i[IDX_W-1:0];
            d.owner       = 1'b1;
            d.eof         = fin && r.tx;
            d.xfer_len    = r.tx ? dlen[CHUNK_W-1:0] : '0;
            d.buf_len     = blen[CHUNK_W-1:0];
            d.seg_addr    = addr;
            d.next_valid  = !fin;
            d.last        = fin;
            d.bound_bytes = fin ? bound[LEN_W-1:0] : '0;
            expected_descs.push_back(d);
            addr = addr + dlen;
        end
    endtask

    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                                input logic [CNT_W-1:0] cnt, input logic tx, input logic ext);
        int   gap;
        req_t r;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_enabled && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r = '{addr, len, cnt, tx, ext};
        req_bus.buf_addr   <= addr;
        req_bus.length     <= len;
        req_bus.desc_count <= cnt;
        req_bus.tx         <= tx;
        req_bus.in_ext_mem <= ext;
        req_bus.valid      <= 1'b1;
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
        build_chain(r);
    endtask

    task automatic wait_for_idle();
        req_bus.valid <= 1'b0;
        while (expected_descs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] value);
        wait_for_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_MAX_CHUNK:   cfg_shadow.max_chunk      = value[CHUNK_W-1:0];
            REG_BURST_CHUNK: cfg_shadow.burst_chunk    = value[CHUNK_W-1:0];
            REG_BURST_EN:    cfg_shadow.burst_enable   = value[0];
            REG_EXT_BLOCK:   cfg_shadow.ext_block_size = value[1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_registers(input int mc, input int bc, input int be, input int eb);
        write_register(REG_MAX_CHUNK, mc);
        write_register(REG_BURST_CHUNK, bc);
        write_register(REG_BURST_EN, be);
        write_register(REG_EXT_BLOCK, eb);
    endtask

    task automatic test_default_config();
        send_request('0, 24'd1, 7'd1, 1'b1, 1'b0);
        send_request('1, '1, 7'd127, 1'b1, 1'b0);
        send_request(32'h0000_0040, '0, 7'd1, 1'b0, 1'b0);
        send_request(32'h1000_0003, 24'd4095, 7'd0, 1'b0, 1'b0);
        send_request(32'hFFFF_F000, 24'd8191, 7'd64, 1'b1, 1'b1);
        send_request(32'h2000_0000, 24'd12000, 7'd2, 1'b0, 1'b0);
        send_request(32'h8000_0001, 24'd4096, 7'd65, 1'b1, 1'b0);
    endtask

    task automatic test_ext_blocks();
        int b;
        for (b = 0; b < 4; b++) begin
            write_register(REG_EXT_BLOCK, b);
            send_request($urandom, 24'd4100, 7'd3, 1'b0, 1'b1);
            send_request($urandom, 24'd61, 7'd1, 1'b0, 1'b1);
        end
        write_register(REG_EXT_BLOCK, 0);
    endtask

    task automatic test_burst_mode();
        write_register(REG_BURST_EN, 1);
        write_register(REG_BURST_CHUNK, 4094);
        send_request($urandom, 24'd9000, 7'd8, 1'b0, 1'b0);
        send_request($urandom, 24'd3, 7'd1, 1'b0, 1'b0);
        send_request($urandom, 24'd5000, 7'd4, 1'b0, 1'b1);
        send_request($urandom, 24'd5000, 7'd4, 1'b1, 1'b0);
        write_register(REG_BURST_CHUNK, 4);
        send_request($urandom, 24'd13, 7'd5, 1'b0, 1'b0);
        write_register(REG_BURST_CHUNK, 3);
        send_request($urandom, 24'd10, 7'd3, 1'b0, 1'b0);
        write_register(REG_BURST_EN, 0);
        write_register(REG_BURST_CHUNK, PDATA_W'(RST_BURST_CHUNK));
    endtask

    task automatic test_zero_chunk();
        write_register(REG_MAX_CHUNK, 0);
        send_request($urandom, 24'd50, 7'd5, 1'b1, 1'b0);
        send_request($urandom, 24'd0, 7'd3, 1'b0, 1'b0);
        write_register(REG_MAX_CHUNK, 1);
        send_request($urandom, 24'd3, 7'd4, 1'b1, 1'b0);
        write_register(REG_MAX_CHUNK, PDATA_W'(RST_MAX_CHUNK));
    endtask

    task automatic send_random_request();
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        int               sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) len = LEN_W'($urandom_range(0, 20000));
        else if (sel == 6) len = LEN_W'($urandom_range(1, 8) * cfg_shadow.max_chunk);
        else if (sel == 7) len = LEN_W'($urandom_range(0, 64));
        else len = LEN_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 8) cnt = CNT_W'($urandom_range(1, MAX_DESC));
        else if (sel == 8) cnt = CNT_W'($urandom_range(MAX_DESC + 1, 127));
        else cnt = CNT_W'($urandom_range(0, 1));
        send_request($urandom, len, cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_traffic();
        int phase, n;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_all_registers(4095, 4092, 1, 2);
                1: write_all_registers(1, 4, 0, 1);
                default: write_all_registers($urandom_range(0, 4095), $urandom_range(0, 4095),
                                             $urandom_range(0, 1), $urandom_range(0, 3));
            endcase
            for (n = 0; n < 65; n++) send_random_request();
        end
        write_all_registers(int'(RST_MAX_CHUNK), int'(RST_BURST_CHUNK), 0, 0);
    endtask

    task automatic test_backpressure();
        int n;
        wait_for_idle();
        gaps_enabled = 1'b0;
        hold_off_req = HOLD_OFF_LEN;
        for (n = 0; n < 30; n++) begin
            send_request($urandom, LEN_W'($urandom_range(1, 9000)),
                         CNT_W'($urandom_range(1, 8)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        gaps_enabled = 1'b1;
    endtask

    // Receiver: stall on a pattern picked at random for runs of random length, or hold ready low on request
    initial begin : desc_receiver
        int mode, left, hold_len, n;
        mode = 0;
        left = 0;
        desc_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req != 0) begin
                hold_len = hold_off_req;
                hold_off_req = 0;
                desc_bus.ready <= 1'b0;
                for (n = 1; n < hold_len; n++) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 64);
                end
                left--;
                case (mode)
                    0: desc_bus.ready <= 1'b1;
                    1: desc_bus.ready <= ($urandom_range(0, 3) != 0);
                    2: desc_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: desc_bus.ready <= left[2];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        desc_t act, exp_d;
        if (i_rst_n && desc_bus.valid === 1'b1 && desc_bus.ready === 1'b1) begin
            act.desc_index  = desc_bus.desc_index;
            act.owner       = desc_bus.owner;
            act.eof         = desc_bus.eof;
            act.xfer_len    = desc_bus.xfer_len;
            act.buf_len     = desc_bus.buf_len;
            act.seg_addr    = desc_bus.seg_addr;
            act.next_valid  = desc_bus.next_valid;
            act.last        = desc_bus.last;
            act.bound_bytes = desc_bus.bound_bytes;
            if (expected_descs.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("unexpected descriptor idx=%0d addr=%h", act.desc_index,
                             act.seg_addr);
                error_count++;
            end else begin
                exp_d = expected_descs.pop_front();
                if (act !== exp_d) begin
                    if (error_count < MAX_REPORTS) begin
                        $display({"exp idx=%0d own=%b eof=%b dlen=%0d blen=%0d addr=%h",
                                  " nv=%b last=%b bound=%0d"},
                                 exp_d.desc_index, exp_d.owner, exp_d.eof, exp_d.xfer_len,
                                 exp_d.buf_len, exp_d.seg_addr, exp_d.next_valid,
                                 exp_d.last, exp_d.bound_bytes);
                        $display({"act idx=%0d own=%b eof=%b dlen=%0d blen=%0d addr=%h",
                                  " nv=%b last=%b bound=%0d"},
                                 act.desc_index, act.owner, act.eof, act.xfer_len,
                                 act.buf_len, act.seg_addr, act.next_valid,
                                 act.last, act.bound_bytes);
                    end
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (desc_bus.valid === 1'b1 && desc_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.buf_addr   <= '0;
        req_bus.length     <= '0;
        req_bus.desc_count <= '0;
        req_bus.tx         <= 1'b0;
        req_bus.in_ext_mem <= 1'b0;
        cfg_shadow = '{RST_MAX_CHUNK, RST_BURST_CHUNK, 1'b0, 2'd0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_config();
        test_ext_blocks();
        test_burst_mode();
        test_zero_chunk();
        test_backpressure();
        test_random_traffic();

        wait_for_idle();
        if (error_count == 0 && expected_descs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dcb_pkg.sv
rtl/dcb_if.sv
rtl/dcb_cfg_regs.sv
rtl/dma_descriptor_chain_builder_unit.sv
verif/dma_descriptor_chain_builder_unit_tb.sv
